[rtl/dvtr_pkg.sv]
// Shared constants and types for the distance-vector table relaxation block.
// Used by the channel interfaces, the table memory, the relax unit and the top level.
package dvtr_pkg;

  localparam int MAX_NODES   = 8;
  localparam int COST_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_NODES);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int MEM_DEPTH   = 1 << ADDR_W;
  localparam int CNT_W       = $clog2(MAX_NODES * MAX_NODES + 1);
  localparam int NODE_W      = 4;
  localparam int COST_FLD_W  = 16;
  localparam int NODE_FLD_W  = 3;
  localparam int NODE_RESET  = 8;

  typedef logic [COST_BITS-1:0] dist_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ADDR_W-1:0]    addr_t;

endpackage

[rtl/dvtr_in_if.sv]
// Input channel for link cost items: valid/ready handshake plus the cost field.
// Depends on dvtr_pkg for the field width.
interface dvtr_in_if;
  import dvtr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COST_FLD_W-1:0] link_cost;
  modport source (output valid, output link_cost, input ready);
  modport sink   (input valid, input link_cost, output ready);
endinterface

[rtl/dvtr_out_if.sv]
// Result channel carrying one routing table entry per item.
// Depends on dvtr_pkg for the field widths.
interface dvtr_out_if;
  import dvtr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [NODE_FLD_W-1:0] router;
  logic [NODE_FLD_W-1:0] destination;
  logic [NODE_FLD_W-1:0] next_hop;
  logic [COST_FLD_W-1:0] distance;
  logic                  last_entry;
  modport source (output valid, output router, output destination, output next_hop,
                  output distance, output last_entry, input ready);
  modport sink   (input valid, input router, input destination, input next_hop,
                  input distance, input last_entry, output ready);
endinterface

[rtl/dvtr_table_mem.sv]
// Distance and next-hop table: one write port, two read ports with registered data.
// Depends on dvtr_pkg for the address and data types.
module dvtr_table_mem (
  input  logic           clk,
  input  logic           we,
  input  dvtr_pkg::addr_t waddr,
  input  dvtr_pkg::dist_t wdist,
  input  dvtr_pkg::idx_t  whop,
  input  dvtr_pkg::addr_t raddr_a,
  input  dvtr_pkg::addr_t raddr_b,
  output dvtr_pkg::dist_t rdist_a,
  output dvtr_pkg::idx_t  rhop_a,
  output dvtr_pkg::dist_t rdist_b
);
  import dvtr_pkg::*;

  dist_t dist_mem [MEM_DEPTH];
  idx_t  hop_mem  [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      dist_mem[waddr] <= wdist;
      hop_mem[waddr]  <= whop;
    end
    rdist_a <= dist_mem[raddr_a];
    rhop_a  <= hop_mem[raddr_a];
    rdist_b <= dist_mem[raddr_b];
  end

endmodule

[rtl/dvtr_relax_alu.sv]
// Shared relaxation unit: saturating sum of two path legs and compare with the best so far.
// Depends on dvtr_pkg for the distance type.
module dvtr_relax_alu (
  input  dvtr_pkg::dist_t leg_a,
  input  dvtr_pkg::dist_t leg_b,
  input  dvtr_pkg::dist_t best,
  output dvtr_pkg::dist_t via,
  output logic            better
);
  import dvtr_pkg::*;

  logic [COST_BITS:0] sum;

  always_comb begin
    sum    = {1'b0, leg_a} + {1'b0, leg_b};
    via    = sum[COST_BITS] ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];
    better = (via < best);
  end

endmodule

[rtl/distance_vector_table_relax_top.sv]
// Distance-vector routing table block: loads a cost matrix, relaxes it once, emits the table.
// Depends on dvtr_pkg, dvtr_in_if, dvtr_out_if, dvtr_table_mem and dvtr_relax_alu.
//
// Usage:
//   cfg_we/cfg_wdata set node_count n (below 2 acts as 2, above 8 as 8). Write it only
//   while the block waits for costs.
//   in_ch takes link costs row-major, one item per cycle while ready is high. The
//   diagonal is stored as zero whatever arrives.
//   After the n*n-th cost, ready drops and a single relax pass runs over pairs i<j and
//   via nodes k, using one saturating adder and comparator. Each pair reads its direct
//   distance, then scans the via nodes k in turn; when its distance improves, both
//   entries i,j and j,i are written back.
//   The table is then sent on out_ch, router by router, one memory read per entry; the
//   next entry is read only once the previous one is in the output register.
//   last_entry marks the final one.
//   An output register parts the channels: the final result may wait in it while the
//   next matrix already loads. A stalled receiver holds emission without loss.
//   Reset (synchronous, rst_n low) sets n to 8 and the load position to zero; the table
//   contents stay undefined until loaded.
module distance_vector_table_relax_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dvtr_pkg::NODE_W-1:0] cfg_wdata,
  dvtr_in_if.sink                     in_ch,
  dvtr_out_if.source                  out_ch
);
  import dvtr_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_FETCH, S_RD, S_CMP, S_WR1, S_WR2, S_EM_RD, S_EM_LD
  } state_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
  } pos_t;

  // Row and column of a row-major position: row is the largest r with r*n <= position.
  function automatic pos_t split_pos(logic [CNT_W-1:0] lc, logic [NODE_W-1:0] n);
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] prod;
    pos_t             p;
    base  = '0;
    p.row = '0;
    for (int r = 1; r < MAX_NODES; r++) begin
      prod = CNT_W'(r) * CNT_W'(n);
      if (prod <= lc) begin
        p.row = IDX_W'(r);
        base  = prod;
      end
    end
    p.col = IDX_W'(lc - base);
    return p;
  endfunction

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  idx_t              i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  dist_t             best_r, best_nxt;
  idx_t              best_hop_r, best_hop_nxt;
  logic              chg_r, chg_nxt;
  logic              out_valid_r, out_valid_nxt;
  idx_t              out_router_r, out_dest_r, out_hop_r;
  dist_t             out_dist_r;
  logic              out_last_r;
  logic              out_load;

  logic [NODE_W-1:0] n_act;
  idx_t              nm1;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  lc_eff, lc_inc;
  pos_t              pos;
  logic              in_fire, out_free, pair_last, emit_last;

  logic   mem_we;
  addr_t  mem_waddr, raddr_a, raddr_b;
  dist_t  mem_wdist, rdist_a, rdist_b, via;
  idx_t   mem_whop, rhop_a;
  logic   better;

  dvtr_table_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdist   (mem_wdist),
    .whop    (mem_whop),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdist_a (rdist_a),
    .rhop_a  (rhop_a),
    .rdist_b (rdist_b)
  );

  dvtr_relax_alu u_alu (
    .leg_a  (rdist_a),
    .leg_b  (rdist_b),
    .best   (best_r),
    .via    (via),
    .better (better)
  );

  always_comb begin
    if (node_r < NODE_W'(2)) begin
      n_act = NODE_W'(2);
    end else if (node_r > NODE_W'(MAX_NODES)) begin
      n_act = NODE_W'(MAX_NODES);
    end else begin
      n_act = node_r;
    end
    nm1       = IDX_W'(n_act - NODE_W'(1));
    total     = CNT_W'(n_act) * CNT_W'(n_act);
    lc_eff    = (load_cnt_r >= total) ? '0 : load_cnt_r;
    lc_inc    = lc_eff + CNT_W'(1);
    pos       = split_pos(lc_eff, n_act);
    in_fire   = in_ch.valid && in_ch.ready;
    out_free  = !out_valid_r || out_ch.ready;
    pair_last = (j_r == nm1) && (i_r == IDX_W'(nm1 - IDX_W'(1)));
    emit_last = (i_r == nm1) && (j_r == nm1);
  end

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = cfg_we ? cfg_wdata : node_r;
    load_cnt_nxt  = load_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    best_hop_nxt  = best_hop_r;
    chg_nxt       = chg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = {i_r, j_r};
    mem_wdist     = best_r;
    mem_whop      = best_hop_r;
    raddr_a       = {i_r, j_r};
    raddr_b       = {k_r, j_r};

    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          mem_we    = 1'b1;
          mem_waddr = {pos.row, pos.col};
          mem_wdist = (pos.row == pos.col) ? '0 : COST_BITS'(in_ch.link_cost);
          mem_whop  = pos.col;
          if (lc_inc == total) begin
            load_cnt_nxt = '0;
            i_nxt        = '0;
            j_nxt        = IDX_W'(1);
            state_nxt    = S_INIT;
          end else begin
            load_cnt_nxt = lc_inc;
          end
        end
      end
      S_INIT: begin
        // Fetch the direct distance of the pair; it seeds the running best.
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        best_nxt     = rdist_a;
        best_hop_nxt = rhop_a;
        chg_nxt      = 1'b0;
        raddr_a      = {i_r, k_r};
        state_nxt    = S_CMP;
      end
      S_RD: begin
        raddr_a   = {i_r, k_r};
        state_nxt = S_CMP;
      end
      S_CMP: begin
        raddr_a = {i_r, k_r};
        if (better) begin
          best_nxt     = via;
          best_hop_nxt = k_r;
        end
        if (k_r == nm1) begin
          k_nxt = '0;
          if (chg_r || better) begin
            state_nxt = S_WR1;
          end else if (pair_last) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_EM_RD;
          end else begin
            state_nxt = S_INIT;
            if (j_r == nm1) begin
              i_nxt = i_r + IDX_W'(1);
              j_nxt = i_r + IDX_W'(2);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end else begin
          chg_nxt   = chg_r || better;
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = {i_r, j_r};
        state_nxt = S_WR2;
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = {j_r, i_r};
        if (pair_last) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_INIT;
          if (j_r == nm1) begin
            i_nxt = i_r + IDX_W'(1);
            j_nxt = i_r + IDX_W'(2);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      S_EM_RD: begin
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (emit_last) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_EM_RD;
            if (j_r == nm1) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      node_r      <= NODE_W'(NODE_RESET);
      load_cnt_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      chg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_r      <= node_nxt;
      load_cnt_r  <= load_cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      chg_r       <= chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    best_hop_r <= best_hop_nxt;
    if (out_load) begin
      out_router_r <= i_r;
      out_dest_r   <= j_r;
      out_hop_r    <= rhop_a;
      out_dist_r   <= rdist_a;
      out_last_r   <= emit_last;
    end
  end

  assign in_ch.ready        = (state_r == S_LOAD);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.router      = NODE_FLD_W'(out_router_r);
  assign out_ch.destination = NODE_FLD_W'(out_dest_r);
  assign out_ch.next_hop    = NODE_FLD_W'(out_hop_r);
  assign out_ch.distance    = COST_FLD_W'(out_dist_r);
  assign out_ch.last_entry  = out_last_r;

  // The running best of a pair can only fall while the via nodes are scanned.
  a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |=> (best_r <= $past(best_r)))
    else $error("relax best distance increased");

  // Relax write-back never touches the diagonal.
  a_no_diag_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR1 || state_r == S_WR2) |-> (i_r != j_r))
    else $error("relax write on diagonal entry");

  // The final table entry is always a router's own entry for itself.
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_entry) |-> (out_ch.router == out_ch.destination))
    else $error("last entry not on diagonal");

  // No cost is taken while a table is being relaxed or emitted.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !in_ch.ready)
    else $error("input ready outside load phase");

endmodule
